### hdl/qst_pkg.sv
// Shared constants and codes for the quintic sweep trajectory block.
`timescale 1ns / 1ps
package qst_pkg;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int TIME_W  = 32;
    localparam int DUR_W   = 31;
    localparam int AMP_W   = 32;
    localparam int POS_W   = 32;
    localparam int VEL_W   = 50;
    localparam int VEL_FRAC = 16;
    localparam int CFG_IDX_W = 1;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TIME = 1'd1;

    // Stroke phase: first stroke, odd stroke, even stroke after the first.
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_UP    = 2'd1;
    localparam logic [1:0] PH_DOWN  = 2'd2;
endpackage

### hdl/qst_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
`timescale 1ns / 1ps
module qst_div #(
    parameter int NB = 47,
    parameter int DW = 31,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NB-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NB-1:0] o_quotient,
    output logic [DW-1:0] o_remainder,
    output logic [SW-1:0] o_side
);
    logic          r_vld  [0:NB];
    logic [DW-1:0] r_rem  [0:NB];
    logic [NB-1:0] r_qd   [0:NB];
    logic [SW-1:0] r_side [0:NB];

    // Entry stage registers the word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rem[0]  <= '0;
        r_qd[0]   <= i_dividend;
        r_side[0] <= i_side;
    end

    // Each stage shifts in one dividend bit and retires one quotient bit.
    for (genvar s = 0; s < NB; s++) begin : g_stage
        logic [DW:0]   cur;
        logic          ge;
        logic [DW:0]   diff;
        logic [DW-1:0] n_rem;

        always_comb begin
            cur   = {r_rem[s], r_qd[s][NB-1]};
            ge    = (cur >= {1'b0, i_divisor});
            diff  = cur - {1'b0, i_divisor};
            n_rem = ge ? diff[DW-1:0] : cur[DW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
            r_rem[s+1]  <= n_rem;
            r_qd[s+1]   <= {r_qd[s][NB-2:0], ge};
            r_side[s+1] <= r_side[s];
        end
    end

    assign o_valid     = r_vld[NB];
    assign o_quotient  = r_qd[NB];
    assign o_remainder = r_rem[NB];
    assign o_side      = r_side[NB];
endmodule

### hdl/quintic_sweep_trajectory_top.sv
// Top level of the quintic sweep trajectory: position and velocity per time word.
`timescale 1ns / 1ps
// A new time word is taken in every cycle (o_busy stays low) and each one gives
// exactly one result, in order. The path runs through two bit-per-stage divider
// pipelines, one that splits the time into stroke index and fraction
// (FRACTION_BITS + 31 stages) and one that divides the velocity by the duration
// (50 stages), around a six-stage polynomial datapath and the output register.
// Results appear for one cycle with o_done high and are not held.
// Write the configuration only while no word is in flight.
module quintic_sweep_trajectory_top
    #(
    parameter int FRACTION_BITS = qst_pkg::FRACTION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [qst_pkg::TIME_W-1:0]  i_elapsed_time,
    output logic                               o_done,
    output logic signed [qst_pkg::POS_W-1:0]   o_position,
    output logic signed [qst_pkg::VEL_W-1:0]   o_velocity,
    input  logic                               i_cfg_we,
    input  logic [qst_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [qst_pkg::AMP_W-1:0]          i_cfg_data
);
    import qst_pkg::*;

    localparam int F    = FRACTION_BITS;
    localparam int NB1  = DUR_W + F;
    localparam int IW   = 2*F + 5;
    localparam int X3L  = (3*F) / 2;
    localparam int X3H  = 3*F - X3L;
    localparam int VW   = 5*F + 2;
    localparam int CV   = (VW + 31) / 32;
    localparam int VPW  = VW + 32;
    localparam int MW   = 4*F + 6;
    localparam int CM   = (MW + 31) / 32;
    localparam int MPW  = MW + 32;
    localparam int VS   = 4*F - VEL_FRAC;
    localparam int WW   = VEL_W;
    localparam int SW2  = POS_W + 2;

    logic signed [AMP_W-1:0] r_amp;
    logic [DUR_W-1:0]        r_dur;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amp <= '0;
            r_dur <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_AMPLITUDE: r_amp <= i_cfg_data;
                REG_HALF_TIME: r_dur <= i_cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic              aneg;
    logic [AMP_W-1:0]  amag;
    assign aneg = r_amp[AMP_W-1];
    assign amag = aneg ? (AMP_W)'(-r_amp) : r_amp;

    // Clamp negative time to zero and divide time * 2^F by the duration.
    logic [DUR_W-1:0] t_clamp;
    logic             d1_valid;
    logic [NB1-1:0]   d1_q;
    logic [DUR_W-1:0] d1_rem;
    logic             d1_dz;

    assign t_clamp = i_elapsed_time[TIME_W-1] ? '0 : i_elapsed_time[DUR_W-1:0];

    qst_div #(.NB(NB1), .DW(DUR_W), .SW(1)) u_div_time (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_start),
        .i_dividend  ({t_clamp, F'(0)}),
        .i_divisor   (r_dur),
        .i_side      (r_dur == '0),
        .o_valid     (d1_valid),
        .o_quotient  (d1_q),
        .o_remainder (d1_rem),
        .o_side      (d1_dz)
    );

    // Stage 1: fraction, phase and first products.
    logic          r_v1, r_dz1;
    logic [1:0]    r_ph1;
    logic [F-1:0]  r_x1;
    logic [2*F-1:0] r_x2, r_xy;
    logic [DUR_W-1:0] k;
    logic [F:0]    y;
    logic [1:0]    n_ph;

    always_comb begin
        k = d1_q[NB1-1:F];
        y = (F+1)'(1) << F;
        y = y - {1'b0, d1_q[F-1:0]};
        if (k == '0) begin
            n_ph = PH_START;
        end else if (k[0]) begin
            n_ph = PH_UP;
        end else begin
            n_ph = PH_DOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= d1_valid;
        end
        r_dz1 <= d1_dz | (d1_rem == '0 && 1'b0);
        r_ph1 <= n_ph;
        r_x1  <= d1_q[F-1:0];
        r_x2  <= (2*F)'(d1_q[F-1:0]) * (2*F)'(d1_q[F-1:0]);
        r_xy  <= (2*F)'((2*F+1)'(d1_q[F-1:0]) * (2*F+1)'(y));
    end

    // Stage 2: cube, inner polynomial and slope square.
    logic          r_v2, r_dz2;
    logic [1:0]    r_ph2;
    logic [3*F-1:0] r_x3;
    logic [IW-1:0] r_inner;
    logic [4*F-1:0] r_z2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_dz2   <= r_dz1;
        r_ph2   <= r_ph1;
        r_x3    <= (3*F)'(r_x2) * (3*F)'(r_x1);
        r_inner <= (IW'(10) << (2*F)) + IW'(6) * IW'(r_x2) - ((IW'(15) * IW'(r_x1)) << F);
        r_z2    <= (4*F)'(r_xy) * (4*F)'(r_xy);
    end

    // Stage 3: scaled smoothstep as two partial products, and scaled slope.
    logic          r_v3, r_dz3;
    logic [1:0]    r_ph3;
    logic [X3L+IW-1:0] r_pl;
    logic [X3H+IW-1:0] r_ph;
    logic [MW-1:0] r_w30;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_dz3 <= r_dz2;
        r_ph3 <= r_ph2;
        r_pl  <= (X3L+IW)'(r_x3[X3L-1:0]) * (X3L+IW)'(r_inner);
        r_ph  <= (X3H+IW)'(r_x3[3*F-1:X3L]) * (X3H+IW)'(r_inner);
        r_w30 <= MW'(30) * MW'(r_z2);
    end

    // Stage 4: join the smoothstep halves and fold in the stroke endpoints.
    logic          r_v4, r_dz4, r_pn4, r_vn4;
    logic [VW-1:0] r_vpos;
    logic [MW-1:0] r_m;
    logic [VW-1:0] full, p2, n_vpos, p_sum;
    logic          n_vneg;

    always_comb begin
        p_sum  = VW'(r_pl) + (VW'(r_ph) << X3L);
        full   = VW'(1) << (5*F);
        p2     = p_sum << 1;
        n_vpos = p_sum;
        n_vneg = 1'b0;
        if (r_ph3 != PH_START) begin
            if (full >= p2) begin
                n_vpos = full - p2;
                n_vneg = (r_ph3 == PH_DOWN);
            end else begin
                n_vpos = p2 - full;
                n_vneg = (r_ph3 == PH_UP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_dz4  <= r_dz3;
        r_pn4  <= aneg != n_vneg;
        r_vn4  <= aneg != (r_ph3 == PH_UP);
        r_vpos <= n_vpos;
        r_m    <= (r_ph3 == PH_START) ? r_w30 : (r_w30 << 1);
    end

    // Stage 5: partial products of 32-bit slices with the amplitude magnitude.
    logic          r_v5, r_dz5, r_pn5, r_vn5;
    logic [63:0]   r_ppv [0:CV-1];
    logic [63:0]   r_ppm [0:CM-1];
    logic [32*CV-1:0] vpos_ext;
    logic [32*CM-1:0] m_ext;

    assign vpos_ext = (32*CV)'(r_vpos);
    assign m_ext    = (32*CM)'(r_m);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else begin
            r_v5 <= r_v4;
        end
        r_dz5 <= r_dz4;
        r_pn5 <= r_pn4;
        r_vn5 <= r_vn4;
    end

    for (genvar c = 0; c < CV; c++) begin : g_ppv
        always_ff @(posedge i_clk) begin
            r_ppv[c] <= 64'(vpos_ext[32*c +: 32]) * 64'(amag);
        end
    end

    for (genvar c = 0; c < CM; c++) begin : g_ppm
        always_ff @(posedge i_clk) begin
            r_ppm[c] <= 64'(m_ext[32*c +: 32]) * 64'(amag);
        end
    end

    // Stage 6: sum the partial products, floor the position (clamped at the positive maximum), prescale velocity.
    logic          r_v6, r_dz6, r_vn6;
    logic [POS_W-1:0] r_pos6;
    logic [WW-1:0] r_w6;
    logic [VPW-1:0] pprod;
    logic [MPW-1:0] mprod;
    logic [VPW-5*F-1:0] pmag;
    logic           plost, vlost;
    logic [POS_W-1:0] n_pos;

    always_comb begin
        pprod = '0;
        for (int c = 0; c < CV; c++) begin
            pprod = pprod + (VPW'(r_ppv[c]) << (32*c));
        end
        mprod = '0;
        for (int c = 0; c < CM; c++) begin
            mprod = mprod + (MPW'(r_ppm[c]) << (32*c));
        end
        plost = |pprod[5*F-1:0];
        pmag  = pprod[VPW-1:5*F] + (VPW-5*F)'(plost & r_pn5);
        if (r_pn5) begin
            n_pos = -pmag[POS_W-1:0];
        end else if (pmag > (VPW-5*F)'({1'b0, {(POS_W-1){1'b1}}})) begin
            n_pos = {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            n_pos = pmag[POS_W-1:0];
        end
        vlost = |mprod[VS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else begin
            r_v6 <= r_v5;
        end
        r_dz6  <= r_dz5;
        r_vn6  <= r_vn5;
        r_pos6 <= n_pos;
        r_w6   <= mprod[VS +: WW] + WW'(vlost & r_vn5);
    end

    // Velocity divide by the duration; the position rides along.
    logic             d2_valid;
    logic [WW-1:0]    d2_q;
    logic [DUR_W-1:0] d2_rem;
    logic [SW2-1:0]   d2_side;

    qst_div #(.NB(WW), .DW(DUR_W), .SW(SW2)) u_div_vel (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_v6),
        .i_dividend  (r_w6),
        .i_divisor   (r_dur),
        .i_side      ({r_dz6, r_vn6, r_pos6}),
        .o_valid     (d2_valid),
        .o_quotient  (d2_q),
        .o_remainder (d2_rem),
        .o_side      (d2_side)
    );

    // Output word register.
    logic             r_done;
    logic [POS_W-1:0] r_pos;
    logic [VEL_W-1:0] r_vel;
    logic [WW-1:0]    vmag;
    logic             o_dz, o_vn;

    always_comb begin
        o_dz = d2_side[SW2-1];
        o_vn = d2_side[SW2-2];
        vmag = d2_q + WW'(o_vn && (d2_rem != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d2_valid;
        end
        r_pos <= o_dz ? '0 : d2_side[POS_W-1:0];
        r_vel <= o_dz ? '0 : (o_vn ? VEL_W'(-vmag) : VEL_W'(vmag));
    end

    assign o_done     = r_done;
    assign o_position = r_pos;
    assign o_velocity = r_vel;
endmodule
